// ===== rtl/stq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int ID_WIDTH      = 16;
   localparam int DELAY_WIDTH   = 16;

   // item kinds
   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_FIRE   = 1'b1;

   // add status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic                   func;
      logic [ID_WIDTH-1:0]    task_id;
      logic [DELAY_WIDTH-1:0] delay;
   } req_type;

   typedef struct packed {
      logic                kind;
      logic [ID_WIDTH-1:0] fired_id;
      logic                status;
      logic                last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_DRAIN,
      ST_FLUSH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture the request, clear the scan counter
      logic add;      // store into the first free slot and answer
      logic scan_rd;  // read the slot under the scan counter and advance
      logic flush;    // emit the held fire as the last one
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_end; // scan counter sits on the highest slot
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/stq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/stq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             func,
   input  wire stq_pkg::sts_type sts,
   output      stq_pkg::cmd_type cmd,
   output      logic             busy
);

   stq_pkg::state_type state_ff;
   stq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         stq_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = (func == stq_pkg::FUNC_ADD) ? stq_pkg::ST_ADD : stq_pkg::ST_SCAN;
            end
         end
         stq_pkg::ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = stq_pkg::ST_IDLE;
         end
         stq_pkg::ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.scan_end) begin
               state_in = stq_pkg::ST_DRAIN;
            end
         end
         // last slot's read data is processed here
         stq_pkg::ST_DRAIN: begin
            state_in = stq_pkg::ST_FLUSH;
         end
         stq_pkg::ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = stq_pkg::ST_IDLE;
         end
         default: begin
            state_in = stq_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_drain_to_flush: assert property (@(posedge clock) disable iff (reset)
      state_ff == stq_pkg::ST_DRAIN |=> state_ff == stq_pkg::ST_FLUSH)
      else $error("drain not followed by flush");

   a_add_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == stq_pkg::ST_ADD |=> state_ff == stq_pkg::ST_IDLE)
      else $error("add took more than one cycle");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy && start)
      else $error("request captured while busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/stq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stq_datapath #(
   parameter int SLOTS = stq_pkg::SLOTS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire stq_pkg::req_type req_data,
   input  wire stq_pkg::cmd_type cmd,
   output      stq_pkg::sts_type sts,
   output      logic             rsp_strobe,
   output      stq_pkg::rsp_type rsp_data
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   stq_pkg::req_type              req_ff;
   logic [IW-1:0]                 cnt_ff;
   logic [IW-1:0]                 cnt_in;
   logic                          s2_valid_ff;
   logic [IW-1:0]                 s2_idx_ff;
   logic [SLOTS-1:0]              valid_ff;
   logic [SLOTS-1:0]              valid_in;
   logic                          pend_ff;
   logic                          pend_in;
   logic [stq_pkg::ID_WIDTH-1:0]  pend_id_ff;
   logic [stq_pkg::ID_WIDTH-1:0]  pend_id_in;
   logic                          rsp_strobe_ff;
   logic                          rsp_strobe_in;
   stq_pkg::rsp_type              rsp_ff;
   stq_pkg::rsp_type              rsp_in;

   logic [IW-1:0]                    free_idx;
   logic                             full;
   logic                             store;
   logic                             slot_live;
   logic                             expire;
   logic [stq_pkg::DELAY_WIDTH-1:0]  rem_rd;
   logic [stq_pkg::ID_WIDTH-1:0]     task_rd;
   logic                             rem_wr_en;
   logic [IW-1:0]                    rem_wr_addr;
   logic [stq_pkg::DELAY_WIDTH-1:0]  rem_wr_data;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   assign full      = &valid_ff;
   assign store     = cmd.add && !full;
   assign slot_live = s2_valid_ff && valid_ff[s2_idx_ff];
   assign expire    = slot_live && (rem_rd <= stq_pkg::DELAY_WIDTH'(1));

   assign rem_wr_en   = store || (slot_live && !expire);
   assign rem_wr_addr = cmd.add ? free_idx : s2_idx_ff;
   assign rem_wr_data = cmd.add ?
                        ((req_ff.delay == '0) ? stq_pkg::DELAY_WIDTH'(1) : req_ff.delay) :
                        (rem_rd - stq_pkg::DELAY_WIDTH'(1));

   stq_ram #(
      .WIDTH (stq_pkg::DELAY_WIDTH),
      .DEPTH (SLOTS)
   ) u_rem_ram (
      .clock   (clock),
      .wr_en   (rem_wr_en),
      .wr_addr (rem_wr_addr),
      .wr_data (rem_wr_data),
      .rd_en   (cmd.scan_rd),
      .rd_addr (cnt_ff),
      .rd_data (rem_rd)
   );

   stq_ram #(
      .WIDTH (stq_pkg::ID_WIDTH),
      .DEPTH (SLOTS)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (free_idx),
      .wr_data (req_ff.task_id),
      .rd_en   (cmd.scan_rd),
      .rd_addr (cnt_ff),
      .rd_data (task_rd)
   );

   always_comb begin
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      pend_in       = pend_ff;
      pend_id_in    = pend_id_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      if (cmd.load) begin
         cnt_in = '0;
      end else if (cmd.scan_rd) begin
         cnt_in = cnt_ff + IW'(1);
      end

      if (store) begin
         valid_in[free_idx] = 1'b1;
      end

      if (cmd.add) begin
         rsp_strobe_in   = 1'b1;
         rsp_in.kind     = stq_pkg::KIND_STATUS;
         rsp_in.fired_id = '0;
         rsp_in.status   = full ? stq_pkg::STATUS_FULL : stq_pkg::STATUS_OK;
         rsp_in.last     = 1'b1;
      end

      // a fire is held one step so the final one of a tick can carry last
      if (expire) begin
         valid_in[s2_idx_ff] = 1'b0;
         pend_in             = 1'b1;
         pend_id_in          = task_rd;
         if (pend_ff) begin
            rsp_strobe_in   = 1'b1;
            rsp_in.kind     = stq_pkg::KIND_FIRE;
            rsp_in.fired_id = pend_id_ff;
            rsp_in.status   = stq_pkg::STATUS_OK;
            rsp_in.last     = 1'b0;
         end
      end

      if (cmd.flush && pend_ff) begin
         pend_in         = 1'b0;
         rsp_strobe_in   = 1'b1;
         rsp_in.kind     = stq_pkg::KIND_FIRE;
         rsp_in.fired_id = pend_id_ff;
         rsp_in.status   = stq_pkg::STATUS_OK;
         rsp_in.last     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         s2_valid_ff   <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         valid_ff      <= valid_in;
         s2_valid_ff   <= cmd.scan_rd;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      s2_idx_ff  <= cnt_ff;
      pend_id_ff <= pend_id_in;
      rsp_ff     <= rsp_in;
   end

   assign sts.scan_end = (cnt_ff == IW'(SLOTS - 1));
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_data     = rsp_ff;

`ifndef SYNTHESIS
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.kind == stq_pkg::KIND_STATUS |-> rsp_ff.last)
      else $error("add answer without last");

   a_fire_status_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.kind == stq_pkg::KIND_FIRE |-> rsp_ff.status == stq_pkg::STATUS_OK)
      else $error("fire result with nonzero status");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      cmd.add |-> !s2_valid_ff)
      else $error("add write collides with scan write-back");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> !pend_ff)
      else $error("held fire survived flush");
`endif

endmodule

`default_nettype wire

// ===== rtl/software_timer_queue.sv =====
// Add: the status result is registered in ST_ADD and strobes with the controller back
//   in idle, and the next item may be accepted at the edge that ends that strobe cycle.
// Tick: busy through ST_SCAN, ST_DRAIN and ST_FLUSH, one slot read per cycle from the
//   task and remaining-count RAMs; fires stream out in slot order, the last one in the final
//   busy cycle's successor. A new tick is taken only once the controller is back in idle.
// Results are never stalled: each strobe lasts one cycle.
// Synchronous reset frees every slot (valid flops) and returns the controller to idle.
`timescale 1ns / 1ps
`default_nettype none

module software_timer_queue #(
   parameter int SLOTS = stq_pkg::SLOTS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire stq_pkg::req_type req_data,
   output      logic             rsp_strobe,
   output      stq_pkg::rsp_type rsp_data
);

   stq_pkg::cmd_type cmd;
   stq_pkg::sts_type sts;

   stq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .func  (req_data.func),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   stq_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
